### rtl/supply_voltage_from_bandgap_filter_assert.svh
// Assertion macros used by the supply voltage filter port checker.
`ifndef SUPPLY_VOLTAGE_FROM_BANDGAP_FILTER_ASSERT_SVH
`define SUPPLY_VOLTAGE_FROM_BANDGAP_FILTER_ASSERT_SVH

// Same-cycle implication.
`define SVBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svbf assertion failed");

// Next-cycle implication.
`define SVBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svbf assertion failed");

`endif

### rtl/svbf_pkg.sv
// Shared types and constants for the bandgap supply voltage filter.
package svbf_pkg;

    localparam int ADC_SAMPLE_W = 10;
    localparam int SCALE_W      = 24;
    localparam int MV_W         = 16;
    localparam int FILT_W       = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam int FILTER_SHIFT_DEFAULT = 7;
    localparam int ADC_BITS_DEFAULT     = 10;

    localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd1126400;
    localparam logic [MV_W-1:0]    THRESHOLD_RESET = 16'd1000;
    localparam logic [MV_W-1:0]    MV_MAX          = 16'hFFFF;
    localparam logic [FILT_W-1:0]  FILT_MAX        = 24'hFFFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_SCALE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESEED_THRESHOLD = 2'd1;

    typedef struct packed {
        logic load;      // capture request and start divide
        logic div_step;  // one quotient bit
        logic update;    // filter update and result write
    } svbf_cmd_t;

    typedef struct packed {
        logic sample_zero;
        logic div_last;
    } svbf_status_t;

endpackage

### rtl/svbf_ctrl.sv
// Sequencer for request capture, divide, filter update and result handoff.
module svbf_ctrl
    import svbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  svbf_status_t status,
    output svbf_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last || status.sample_zero)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/svbf_dp.sv
// Datapath: config registers, restoring divider, filter register, result register.
module svbf_dp
    import svbf_pkg::*;
#(
    parameter int FILTER_SHIFT = FILTER_SHIFT_DEFAULT,
    parameter int ADC_BITS     = ADC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [ADC_SAMPLE_W-1:0] adc_sample,
    input  logic                   restart,
    input  svbf_cmd_t              cmd,
    output svbf_status_t           status,
    output logic [MV_W-1:0]        voltage_mv
);

    localparam int SAMPLE_W = (ADC_BITS < ADC_SAMPLE_W) ? ADC_BITS : ADC_SAMPLE_W;
    localparam int CNT_W    = $clog2(SCALE_W);
    localparam int W        = FILT_W + FILTER_SHIFT;

    logic [SCALE_W-1:0]  scale_reg;
    logic [MV_W-1:0]     thr_reg;
    logic [FILT_W-1:0]   filt_reg;
    logic [SCALE_W-1:0]  quo_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] divisor_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                zero_reg;
    logic [MV_W-1:0]     voltage_reg;

    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                ge;
    logic [MV_W-1:0]     mv;
    logic [W-1:0]        filt_ext;
    logic [W-1:0]        thr_ext;
    logic [W-1:0]        reseed_val;
    logic [W-1:0]        decay_val;
    logic [W-1:0]        raw_next;
    logic [FILT_W-1:0]   filt_next;
    logic [FILT_W-1:0]   out_shift;

    assign sample = adc_sample[SAMPLE_W-1:0];

    // Restoring divide, one quotient bit per step; numerator shifts out of quo_reg.
    assign trial = {rem_reg, quo_reg[SCALE_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign ge    = (trial >= {1'b0, divisor_reg});

    assign status.sample_zero = zero_reg;
    assign status.div_last    = (cnt_reg == '0);

    always_comb
    begin
        if (zero_reg)
        begin
            mv = '0;
        end
        else if (|quo_reg[SCALE_W-1:MV_W])
        begin
            mv = MV_MAX;
        end
        else
        begin
            mv = quo_reg[MV_W-1:0];
        end
    end

    // Decay is filt*(2^S-1) >> S, done as (filt<<S - filt) >> S.
    assign filt_ext   = W'(filt_reg);
    assign thr_ext    = W'(thr_reg) << FILTER_SHIFT;
    assign reseed_val = W'(mv) << FILTER_SHIFT;
    assign decay_val  = ((filt_ext << FILTER_SHIFT) - filt_ext) >> FILTER_SHIFT;
    assign raw_next   = (filt_ext < thr_ext) ? reseed_val : (decay_val + W'(mv));
    assign filt_next  = (raw_next > W'(FILT_MAX)) ? FILT_MAX : raw_next[FILT_W-1:0];
    assign out_shift  = filt_next >> FILTER_SHIFT;

    assign voltage_mv = voltage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            thr_reg   <= THRESHOLD_RESET;
            filt_reg  <= '0;
            cnt_reg   <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REFERENCE_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_RESEED_THRESHOLD: thr_reg   <= cfg_data[MV_W-1:0];
                    default:              ;
                endcase
            end
            if (cmd.load)
            begin
                cnt_reg  <= CNT_W'(SCALE_W - 1);
                zero_reg <= (sample == '0);
                if (restart)
                begin
                    filt_reg <= '0;
                end
            end
            else
            begin
                if (cmd.div_step && (cnt_reg != '0))
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                if (cmd.update)
                begin
                    filt_reg <= filt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg     <= scale_reg;
            rem_reg     <= '0;
            divisor_reg <= sample;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SCALE_W-2:0], ge};
            rem_reg <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        end
        if (cmd.update)
        begin
            voltage_reg <= (|out_shift[FILT_W-1:MV_W]) ? MV_MAX : out_shift[MV_W-1:0];
        end
    end

endmodule

### rtl/supply_voltage_from_bandgap_filter.sv
// Supply voltage monitor: bandgap ADC reading to filtered supply millivolts.
// Each request is taken from idle and goes through the restoring divider that
// forms reference_scale / adc_sample one quotient bit per cycle, and then the
// filter update, after which in_ready returns and the result is loaded. A zero
// reading ends the divide after its first step, then goes to the update. The
// result sits in an output register, so the next request is taken while it
// waits; the update stalls only if the previous result is still unclaimed.
// Configuration writes are always accepted (cfg_ready is high) and must only
// be issued while the block is idle; indexes beyond the register list are ignored.
module supply_voltage_from_bandgap_filter
    import svbf_pkg::*;
#(
    parameter int FILTER_SHIFT = FILTER_SHIFT_DEFAULT,
    parameter int ADC_BITS     = ADC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ADC_SAMPLE_W-1:0] adc_sample,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MV_W-1:0]         voltage_mv
);

    svbf_cmd_t    cmd;
    svbf_status_t status;

    assign cfg_ready = 1'b1;

    svbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    svbf_dp #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .ADC_BITS     (ADC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .adc_sample (adc_sample),
        .restart    (restart),
        .cmd        (cmd),
        .status     (status),
        .voltage_mv (voltage_mv)
    );

endmodule

### rtl/svbf_checker.sv
// Port-level checker for the supply voltage filter, bound to the top level.
`include "supply_voltage_from_bandgap_filter_assert.svh"

module svbf_checker
    import svbf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [MV_W-1:0]         voltage_mv
);

    // Stalled result holds.
    `SVBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(voltage_mv))
    // One request at a time: busy right after a request is taken.
    `SVBF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // No result can be produced in the cycle right after acceptance.
    `SVBF_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    // A fresh result always coincides with the block going idle again.
    `SVBF_ASSERT_IMPLY(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind supply_voltage_from_bandgap_filter svbf_checker u_checker (.*);

### bench/svbf_voltage_checker.sv
// Checker for the bandgap supply voltage filter: predicts each filtered voltage and compares.
module svbf_voltage_checker
    import svbf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [ADC_SAMPLE_W-1:0] adc_sample,
    input  logic                    restart,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [MV_W-1:0]         voltage_mv,
    output int                      failures,
    output int                      pending
);

    logic [SCALE_W-1:0] ref_scale  = SCALE_RESET;
    logic [MV_W-1:0]    reseed_mv  = THRESHOLD_RESET;
    logic [FILT_W-1:0]  filter_acc = '0;
    logic [MV_W-1:0]    expected_mv[$];
    int                 fail_count = 0;

    // Runs one reading through the divider and the moving average.
    function automatic logic [MV_W-1:0] advance_filter(input logic [ADC_SAMPLE_W-1:0] sample,
                                                       input logic clear);
        logic [63:0] reading;
        logic [63:0] scale;
        logic [63:0] inst_mv;
        logic [63:0] acc;
        logic [63:0] floor_acc;
        logic [63:0] next_acc;
        logic [63:0] level;
        reading = '0;
        reading[ADC_SAMPLE_W-1:0] = sample;
        reading = reading & ((64'd1 << ADC_BITS_DEFAULT) - 64'd1);
        scale = '0;
        scale[SCALE_W-1:0] = ref_scale;
        if (clear)
            filter_acc = '0;
        if (reading == 64'd0)
            inst_mv = 64'd0;
        else
        begin
            inst_mv = scale / reading;
            if (inst_mv > MV_MAX)
                inst_mv = MV_MAX;
        end
        acc = '0;
        acc[FILT_W-1:0] = filter_acc;
        floor_acc = '0;
        floor_acc[MV_W-1:0] = reseed_mv;
        floor_acc = floor_acc << FILTER_SHIFT_DEFAULT;
        // below the reseed level the filter jumps straight to the new reading
        if (acc < floor_acc)
            next_acc = inst_mv << FILTER_SHIFT_DEFAULT;
        else
            next_acc = ((acc * ((64'd1 << FILTER_SHIFT_DEFAULT) - 64'd1)) >> FILTER_SHIFT_DEFAULT)
                       + inst_mv;
        if (next_acc > FILT_MAX)
            next_acc = FILT_MAX;
        filter_acc = next_acc[FILT_W-1:0];
        level = next_acc >> FILTER_SHIFT_DEFAULT;
        if (level > MV_MAX)
            level = MV_MAX;
        return level[MV_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [MV_W-1:0] want;
        if (!rst_n)
        begin
            ref_scale  = SCALE_RESET;
            reseed_mv  = THRESHOLD_RESET;
            filter_acc = '0;
            expected_mv.delete();
            failures <= fail_count;
            pending  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_REFERENCE_SCALE:  ref_scale = cfg_data[SCALE_W-1:0];
                    REG_RESEED_THRESHOLD: reseed_mv = cfg_data[MV_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_mv.size() == 0)
                begin
                    $display("%0t: voltage_mv expected none actual %0d", $time, voltage_mv);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_mv.pop_front();
                    if (voltage_mv !== want)
                    begin
                        $display("%0t: voltage_mv expected %0d actual %0d",
                                 $time, want, voltage_mv);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_mv.push_back(advance_filter(adc_sample, restart));
            failures <= fail_count;
            pending  <= expected_mv.size();
        end
    end

endmodule

### bench/supply_voltage_from_bandgap_filter_test.sv
// Testbench top for the bandgap supply voltage filter: stimulus, idling and verdict.
module supply_voltage_from_bandgap_filter_test;
    import svbf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 600000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_REFERENCE_SCALE;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ADC_SAMPLE_W-1:0] adc_sample = '0;
    logic                    restart = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [MV_W-1:0]         voltage_mv;

    int failures;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int cycle_count = 0;

    supply_voltage_from_bandgap_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .voltage_mv (voltage_mv)
    );

    svbf_voltage_checker voltage_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .voltage_mv (voltage_mv),
        .failures   (failures),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("supply_voltage_from_bandgap_filter test failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int seen_holds;
        int held;
        seen_holds = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != seen_holds)
            begin
                seen_holds = hold_requests;
                out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held = held + 1;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Starts and ends on a falling edge; valid stays up for a back-to-back request.
    task automatic send_reading(input logic [ADC_SAMPLE_W-1:0] sample, input logic clear);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= sample;
        restart    <= clear;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register writes wait until every outstanding voltage has come back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        if (pending != 0)
        begin
            cfg_valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly a narrow band so the average settles, with zeros, tiny readings and noise.
    function automatic logic [ADC_SAMPLE_W-1:0] pick_sample(input int center);
        int roll;
        int value;
        roll = $urandom_range(99);
        if (roll < 8)
            value = 0;
        else if (roll < 18)
            value = $urandom_range(15, 1);
        else if (roll < 40)
            value = $urandom_range(1023, 0);
        else
        begin
            value = center + int'($urandom_range(16)) - 8;
            if (value < 1)
                value = 1;
            if (value > 1023)
                value = 1023;
        end
        return value[ADC_SAMPLE_W-1:0];
    endfunction

    initial
    begin
        int center;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero reading, saturated quotient, full scale, restarts
        send_reading(10'd0, 1'b1);
        send_reading(10'd1, 1'b0);
        send_reading(10'd1023, 1'b0);
        send_reading(10'd341, 1'b0);
        send_reading(10'd512, 1'b0);
        send_reading(10'd2, 1'b0);
        send_reading(10'd1023, 1'b1);

        // largest scale with no reseed: filter grows from zero
        write_reg(REG_REFERENCE_SCALE, 24'hFFFFFF);
        write_reg(REG_RESEED_THRESHOLD, 24'd0);
        send_reading(10'd1, 1'b1);
        send_reading(10'd1, 1'b0);
        send_reading(10'd1023, 1'b0);
        send_reading(10'd0, 1'b0);

        // zero scale, threshold at top: always reseeds
        write_reg(REG_REFERENCE_SCALE, 24'd0);
        write_reg(REG_RESEED_THRESHOLD, 24'h00FFFF);
        send_reading(10'd1023, 1'b1);
        send_reading(10'd1, 1'b0);
        send_reading(10'd0, 1'b0);

        // out-of-range indexes must leave the registers alone
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
        send_reading(10'd700, 1'b0);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    write_reg(REG_REFERENCE_SCALE, SCALE_RESET);
                    write_reg(REG_RESEED_THRESHOLD, CFG_DATA_W'(THRESHOLD_RESET));
                end
                2:
                begin
                    write_reg(REG_REFERENCE_SCALE, 24'hFFFFFF);
                    write_reg(REG_RESEED_THRESHOLD, 24'd0);
                end
                4:
                begin
                    write_reg(REG_REFERENCE_SCALE, SCALE_RESET);
                    write_reg(REG_RESEED_THRESHOLD, CFG_DATA_W'($urandom_range(3000)));
                end
                1:
                begin
                    write_reg(REG_REFERENCE_SCALE, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
                    write_reg(REG_RESEED_THRESHOLD, CFG_DATA_W'($urandom_range(4000)));
                end
                default:
                begin
                    write_reg(REG_REFERENCE_SCALE, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
                    write_reg(REG_RESEED_THRESHOLD, CFG_DATA_W'($urandom_range(24'h00FFFF)));
                end
            endcase
            center = $urandom_range(1023, 64);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // result side stops long enough for the block to back up
                if (phase == 0 && i == 100)
                    hold_requests = hold_requests + 1;
                send_reading(pick_sample(center), $urandom_range(99) < 3);
            end
        end

        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("supply_voltage_from_bandgap_filter test passed");
        else
            $display("supply_voltage_from_bandgap_filter test failed");
        $finish;
    end

endmodule
